/* rtl/lgs_pkg.sv */
// lgs_pkg: shared types and constants for the life generation stencil.
// Used by lgs_front, lgs_back and life_generation_stencil_top; no dependencies.

package lgs_pkg;

	localparam int COL_W = 6;
	localparam int ROW_W = 10;

	localparam int DEF_MAX_COLUMNS = 62;
	localparam int DEF_MAX_ROWS    = 1023;

	localparam int MIN_SIZE = 3;

	localparam int RESET_COLUMNS = 40;
	localparam int RESET_ROWS    = 20;

	// depth of both queues, power of two
	localparam int QUEUE_DEPTH = 4;

	typedef logic [COL_W-1:0] col_t;
	typedef logic [ROW_W-1:0] row_t;

	// configuration register indexes
	typedef logic [0:0] cfg_index_t;
	localparam cfg_index_t REG_COLUMNS = 1'b0;
	localparam cfg_index_t REG_ROWS    = 1'b1;

	typedef enum logic [0:0] {
		FS_STREAM,
		FS_FLUSH
	} front_state_t;

	// one window step for the back end
	typedef struct packed {
		logic alive;      // incoming bottom cell
		logic virt;       // flush step below the last row
		col_t col;
		row_t row;
		logic col_first;
		logic col_last;
		logic row_ge1;
		logic row_ge2;
	} cmd_t;

	typedef struct packed {
		logic cell_next;
		col_t cell_column;
		row_t cell_row;
		logic frame_last;
	} result_t;

endpackage

/* rtl/lgs_fifo.sv */
// lgs_fifo: small register queue, up to two pushes and one pop per cycle.
// Standalone; used for the command queue and the result queue.

module lgs_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push0,
	input  logic                         push1,
	input  logic [WIDTH-1:0]             data0,
	input  logic [WIDTH-1:0]             data1,
	input  logic                         pop,
	output logic [WIDTH-1:0]             rd_data,
	output logic                         empty,
	output logic [$clog2(DEPTH):0]       count
);

	localparam int AW = $clog2(DEPTH);

	logic [WIDTH-1:0] store_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [AW:0]      count_q;
	logic [AW-1:0]    wr_ptr_p1;

	// second push lands one slot after the first
	assign wr_ptr_p1 = wr_ptr_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + AW'(push0) + AW'(push1);
			rd_ptr_q <= rd_ptr_q + AW'(pop);
			count_q  <= count_q + (AW+1)'(push0) + (AW+1)'(push1) - (AW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push0) begin
			store_q[wr_ptr_q] <= data0;
		end
		if (push1) begin
			store_q[wr_ptr_p1] <= data1;
		end
	end

	assign rd_data = store_q[rd_ptr_q];
	assign empty   = (count_q == '0);
	assign count   = count_q;

endmodule

/* rtl/lgs_front.sv */
// lgs_front: accepts cells, tracks raster position and classifies each step.
// Emits one command per cell, plus a row of flush steps after the frame's last cell.
// Depends on lgs_pkg.

module lgs_front #(
	parameter int MAX_COLUMNS = lgs_pkg::DEF_MAX_COLUMNS,
	parameter int MAX_ROWS    = lgs_pkg::DEF_MAX_ROWS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  lgs_pkg::col_t cfg_columns,
	input  lgs_pkg::row_t cfg_rows,
	input  logic          push,
	input  logic          cell_in,
	output logic          full,
	input  logic          cmd_full,
	output logic          cmd_push,
	output lgs_pkg::cmd_t cmd_data
);

	import lgs_pkg::*;

	front_state_t state_q, state_d;
	col_t col_q, col_d;
	row_t row_q, row_d;
	col_t fcol_q, fcol_d;

	col_t width, last_col, c_adj;
	row_t height, last_row, r_step, r_adj;
	cmd_t stream_cmd, flush_cmd;

	// clamp grid size to the supported range
	always_comb begin
		if (cfg_columns < col_t'(MIN_SIZE)) begin
			width = col_t'(MIN_SIZE);
		end else if (cfg_columns > col_t'(MAX_COLUMNS)) begin
			width = col_t'(MAX_COLUMNS);
		end else begin
			width = cfg_columns;
		end
		if (cfg_rows < row_t'(MIN_SIZE)) begin
			height = row_t'(MIN_SIZE);
		end else if (cfg_rows > row_t'(MAX_ROWS)) begin
			height = row_t'(MAX_ROWS);
		end else begin
			height = cfg_rows;
		end
		last_col = width - 1'b1;
		last_row = height - 1'b1;
	end

	// position fix-up in case the size shrank since the last cell
	always_comb begin
		c_adj  = (col_q >= width) ? '0 : col_q;
		r_step = (col_q >= width) ? row_q + 1'b1 : row_q;
		r_adj  = (r_step >= height) ? '0 : r_step;
	end

	always_comb begin
		stream_cmd.alive     = cell_in;
		stream_cmd.virt      = 1'b0;
		stream_cmd.col       = c_adj;
		stream_cmd.row       = r_adj;
		stream_cmd.col_first = (c_adj == '0);
		stream_cmd.col_last  = (c_adj == last_col);
		stream_cmd.row_ge1   = (r_adj != '0);
		stream_cmd.row_ge2   = (r_adj >= row_t'(2));

		flush_cmd.alive     = 1'b0;
		flush_cmd.virt      = 1'b1;
		flush_cmd.col       = fcol_q;
		flush_cmd.row       = height;
		flush_cmd.col_first = (fcol_q == '0);
		flush_cmd.col_last  = (fcol_q == last_col);
		flush_cmd.row_ge1   = 1'b1;
		flush_cmd.row_ge2   = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FS_STREAM;
			col_q   <= '0;
			row_q   <= '0;
			fcol_q  <= '0;
		end else begin
			state_q <= state_d;
			col_q   <= col_d;
			row_q   <= row_d;
			fcol_q  <= fcol_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		col_d    = col_q;
		row_d    = row_q;
		fcol_d   = fcol_q;
		cmd_push = 1'b0;
		cmd_data = stream_cmd;
		full     = 1'b1;
		unique case (state_q)
			FS_STREAM: begin
				full = cmd_full;
				if (push && !cmd_full) begin
					cmd_push = 1'b1;
					if (c_adj == last_col) begin
						col_d = '0;
						if (r_adj == last_row) begin
							row_d   = '0;
							fcol_d  = '0;
							state_d = FS_FLUSH;
						end else begin
							row_d = r_adj + 1'b1;
						end
					end else begin
						col_d = c_adj + 1'b1;
						row_d = r_adj;
					end
				end
			end
			FS_FLUSH: begin
				cmd_data = flush_cmd;
				if (!cmd_full) begin
					cmd_push = 1'b1;
					fcol_d   = fcol_q + 1'b1;
					if (fcol_q == last_col) begin
						state_d = FS_STREAM;
					end
				end
			end
			default: begin
				state_d = FS_STREAM;
			end
		endcase
	end

endmodule

/* rtl/lgs_back.sv */
// lgs_back: line buffer memory, 3x3 window and rule evaluation.
// Takes commands from the command queue, pushes up to two results per cycle.
// Depends on lgs_pkg.

module lgs_back #(
	parameter int MAX_COLUMNS = lgs_pkg::DEF_MAX_COLUMNS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_empty,
	input  lgs_pkg::cmd_t    cmd_head,
	output logic             cmd_pop,
	input  logic             res_room,
	output logic             res_push0,
	output logic             res_push1,
	output lgs_pkg::result_t res_lane0,
	output lgs_pkg::result_t res_lane1
);

	import lgs_pkg::*;

	localparam int ColAw = $clog2(MAX_COLUMNS);

	// {upper row, middle row} per column
	logic [1:0] row_mem [MAX_COLUMNS];

	logic       valid_s1;
	cmd_t       cmd_s1;
	logic [1:0] rows_s1;

	// window: [row][col], row 0 on top, col 2 newest
	logic [2:0][2:0] win_q, win_base, win_new, win_tail;

	logic    fire, load, a_valid, b_valid;
	result_t res_a, res_b;
	row_t    row_m1;

	function automatic logic life_next(input logic [2:0][2:0] w);
		logic [3:0] n;
		n = '0;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				if (!(i == 1 && j == 1)) begin
					n = n + 4'(w[i][j]);
				end
			end
		end
		return w[1][1] ? (n == 4'd2 || n == 4'd3) : (n == 4'd3);
	endfunction

	assign fire    = valid_s1 && res_room;
	assign load    = !cmd_empty && (!valid_s1 || fire);
	assign cmd_pop = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			win_q    <= '0;
		end else begin
			if (load) begin
				valid_s1 <= 1'b1;
			end else if (fire) begin
				valid_s1 <= 1'b0;
			end
			if (fire) begin
				win_q <= win_new;
			end
		end
	end

	// read for the incoming step, write back the step leaving; columns differ
	always_ff @(posedge clk) begin
		if (load) begin
			cmd_s1  <= cmd_head;
			rows_s1 <= row_mem[cmd_head.col[ColAw-1:0]];
		end
		if (fire && !cmd_s1.virt) begin
			row_mem[cmd_s1.col[ColAw-1:0]] <= {rows_s1[0], cmd_s1.alive};
		end
	end

	always_comb begin
		win_base = cmd_s1.col_first ? '0 : win_q;
		for (int i = 0; i < 3; i++) begin
			win_new[i][0]  = win_base[i][1];
			win_new[i][1]  = win_base[i][2];
		end
		win_new[0][2] = cmd_s1.row_ge2 & rows_s1[1];
		win_new[1][2] = cmd_s1.row_ge1 & rows_s1[0];
		win_new[2][2] = !cmd_s1.virt & cmd_s1.alive;
		// right edge: one more shift with dead cells
		for (int i = 0; i < 3; i++) begin
			win_tail[i][0] = win_new[i][1];
			win_tail[i][1] = win_new[i][2];
			win_tail[i][2] = 1'b0;
		end
	end

	always_comb begin
		row_m1  = cmd_s1.row - 1'b1;
		a_valid = cmd_s1.row_ge1 && !cmd_s1.col_first;
		b_valid = cmd_s1.row_ge1 && cmd_s1.col_last;

		res_a.cell_next   = life_next(win_new);
		res_a.cell_column = cmd_s1.col - 1'b1;
		res_a.cell_row    = row_m1;
		res_a.frame_last  = 1'b0;

		res_b.cell_next   = life_next(win_tail);
		res_b.cell_column = cmd_s1.col;
		res_b.cell_row    = row_m1;
		res_b.frame_last  = cmd_s1.virt;

		res_push0 = fire && (a_valid || b_valid);
		res_push1 = fire && a_valid && b_valid;
		res_lane0 = a_valid ? res_a : res_b;
		res_lane1 = res_b;
	end

endmodule

/* rtl/life_generation_stencil_top.sv */
// life_generation_stencil_top: streaming Game of Life (B3/S23) next-generation engine.
// Instantiates lgs_front, lgs_fifo (twice) and lgs_back; depends on lgs_pkg.
//
// Usage
// - Input queue: push a cell with push while full is low, row by row, column 0 first.
// - Result queue: while empty is low the oldest result sits on cell_next, cell_column,
//   cell_row and frame_last; pop takes it. frame_last marks the frame's final cell.
// - Config: cfg_valid/cfg_ready with cfg_index (columns, rows) and cfg_data; cfg_ready
//   is always high. Write only while the block is idle.
// - Throughput: one cell per cycle when the back end does not stall; after each frame the
//   front end sends one flush step per column of the last row, with full held high.
//   Back end emits up to two results per cycle at the right edge of a row.
// - Result path: the result for cell (r-1,c-1) is on the result ports once cell (r,c) has
//   passed the command queue write, the line buffer read and the result queue write.
// - Stall: without room for two results the back end stops, the command queue fills,
//   and full rises; nothing is dropped.
// - Reset: size returns to 40x20, position to the top left, window cleared, queues empty.
//   The line buffers are not cleared; rows above the top of the grid are masked.

module life_generation_stencil_top #(
	parameter int MAX_COLUMNS = lgs_pkg::DEF_MAX_COLUMNS,
	parameter int MAX_ROWS    = lgs_pkg::DEF_MAX_ROWS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic                cell_in,
	input  logic                pop,
	output logic                empty,
	output logic                cell_next,
	output lgs_pkg::col_t       cell_column,
	output lgs_pkg::row_t       cell_row,
	output logic                frame_last,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  lgs_pkg::cfg_index_t cfg_index,
	input  lgs_pkg::row_t       cfg_data
);

	import lgs_pkg::*;

	localparam int QAW = $clog2(QUEUE_DEPTH);

	col_t cols_q;
	row_t rows_q;

	// front to command queue
	logic cmd_push, cmd_full, cmd_empty, cmd_pop;
	cmd_t cmd_in, cmd_head;
	logic [$bits(cmd_t)-1:0] cmd_rd;
	logic [QAW:0] cmd_count;

	// back to result queue
	logic res_push0, res_push1, res_room;
	result_t res_lane0, res_lane1, res_head;
	logic [$bits(result_t)-1:0] res_rd;
	logic [QAW:0] res_count;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= col_t'(RESET_COLUMNS);
			rows_q <= row_t'(RESET_ROWS);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_COLUMNS: cols_q <= cfg_data[COL_W-1:0];
				REG_ROWS:    rows_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	lgs_front #(
		.MAX_COLUMNS(MAX_COLUMNS),
		.MAX_ROWS   (MAX_ROWS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_columns(cols_q),
		.cfg_rows   (rows_q),
		.push       (push),
		.cell_in    (cell_in),
		.full       (full),
		.cmd_full   (cmd_full),
		.cmd_push   (cmd_push),
		.cmd_data   (cmd_in)
	);

	assign cmd_full = (cmd_count == (QAW+1)'(QUEUE_DEPTH));

	lgs_fifo #(
		.WIDTH($bits(cmd_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_cmd_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push0  (cmd_push),
		.push1  (1'b0),
		.data0  (cmd_in),
		.data1  ('0),
		.pop    (cmd_pop),
		.rd_data(cmd_rd),
		.empty  (cmd_empty),
		.count  (cmd_count)
	);

	assign cmd_head = cmd_t'(cmd_rd);

	// back end fires only with room for a full pair of results
	assign res_room = (res_count <= (QAW+1)'(QUEUE_DEPTH - 2));

	lgs_back #(
		.MAX_COLUMNS(MAX_COLUMNS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_empty(cmd_empty),
		.cmd_head (cmd_head),
		.cmd_pop  (cmd_pop),
		.res_room (res_room),
		.res_push0(res_push0),
		.res_push1(res_push1),
		.res_lane0(res_lane0),
		.res_lane1(res_lane1)
	);

	lgs_fifo #(
		.WIDTH($bits(result_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_res_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push0  (res_push0),
		.push1  (res_push1),
		.data0  (res_lane0),
		.data1  (res_lane1),
		.pop    (pop && !empty),
		.rd_data(res_rd),
		.empty  (empty),
		.count  (res_count)
	);

	assign res_head    = result_t'(res_rd);
	assign cell_next   = res_head.cell_next;
	assign cell_column = res_head.cell_column;
	assign cell_row    = res_head.cell_row;
	assign frame_last  = res_head.frame_last;

`ifndef ASSERT_OFF
	// the pair lane is only used together with the first lane
	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		res_push1 |-> res_push0)
		else $error("second result pushed without first");

	// result queue never overruns
	a_res_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_count <= (QAW+1)'(QUEUE_DEPTH))
		else $error("result queue overflow");

	// back end only takes commands that are there
	a_cmd_pop: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> !cmd_empty)
		else $error("command popped from empty queue");

	// end of frame is never reported on the top rows
	a_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && frame_last) |-> (cell_row >= row_t'(2)))
		else $error("frame end on an impossible row");
`endif

endmodule
